### hw/rtl/tts_pkg.sv
// Shared types, constants and saturating helper of the tridiagonal solver.
package tts_pkg;

  localparam int DATA_W        = 32;
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam int CNT_W         = 7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_PIVOT = 2'd1;
  localparam logic [1:0] STAT_FEW   = 2'd2;
  localparam logic [1:0] STAT_CAP   = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [1:0]       err;
    logic             few;
  } job_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num1;
    logic signed [DATA_W-1:0] num2;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic                     zero;
    logic signed [DATA_W-1:0] q1;
    logic signed [DATA_W-1:0] q2;
  } div_rsp_t;

  typedef struct packed {
    logic lo;
    logic up;
    logic rh;
    logic an;
  } wr_en_t;

  function automatic logic signed [DATA_W-1:0] qsub(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

### hw/rtl/tridiagonal_twoway_solver.sv
// Top level of the two-way tridiagonal solver.
// Rows are taken one per cycle while no solve is pending or running.
// Each eliminated row and the middle row of a solve wait on the shared radix-4 divider,
// one divide per pivot at Q16.16 by default; substitution and output use no divide.
// Reset clears row count, error mark, sequencer and output valid; stores stay undefined.
module tridiagonal_twoway_solver #(
  parameter int MAX_ROWS  = tts_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = tts_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tts_pkg::DATA_W-1:0] sub_diagonal_i,
  input  logic signed [tts_pkg::DATA_W-1:0] main_diagonal_i,
  input  logic signed [tts_pkg::DATA_W-1:0] super_diagonal_i,
  input  logic signed [tts_pkg::DATA_W-1:0] right_side_i,
  input  logic                              last_row_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tts_pkg::DATA_W-1:0] solution_o,
  output logic                              final_res_o,
  output logic [1:0]                        status_o
);
  import tts_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  logic                     f_we, q_push, q_pop, q_empty, q_full, b_busy, hold;
  logic [AW-1:0]            f_addr, b_raddr, b_waddr;
  job_t                     f_job, q_job;
  wr_en_t                   b_wr;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [DATA_W-1:0] b_coef, b_rhs, b_ans;
  logic signed [DATA_W-1:0] rd_lo, rd_ce, rd_up, rd_rh, rd_an;

  assign hold = ~q_empty | b_busy;

  tts_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .last_row_i (last_row_i),
    .hold_i     (hold),
    .wr_en_o    (f_we),
    .waddr_o    (f_addr),
    .job_push_o (q_push),
    .job_o      (f_job)
  );

  tts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (f_job),
    .pop_i   (q_pop),
    .job_o   (q_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_lower (
    .clk_i   (clk_i),
    .we_i    (f_we | b_wr.lo),
    .waddr_i (f_we ? f_addr : b_waddr),
    .wdata_i (f_we ? sub_diagonal_i : b_coef),
    .raddr_i (b_raddr),
    .rdata_o (rd_lo)
  );

  tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_center (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_addr),
    .wdata_i (main_diagonal_i),
    .raddr_i (b_raddr),
    .rdata_o (rd_ce)
  );

  tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_upper (
    .clk_i   (clk_i),
    .we_i    (f_we | b_wr.up),
    .waddr_i (f_we ? f_addr : b_waddr),
    .wdata_i (f_we ? super_diagonal_i : b_coef),
    .raddr_i (b_raddr),
    .rdata_o (rd_up)
  );

  tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs (
    .clk_i   (clk_i),
    .we_i    (f_we | b_wr.rh),
    .waddr_i (f_we ? f_addr : b_waddr),
    .wdata_i (f_we ? right_side_i : b_rhs),
    .raddr_i (b_raddr),
    .rdata_o (rd_rh)
  );

  tts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_answer (
    .clk_i   (clk_i),
    .we_i    (b_wr.an),
    .waddr_i (b_waddr),
    .wdata_i (b_ans),
    .raddr_i (b_raddr),
    .rdata_o (rd_an)
  );

  tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tts_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (~q_empty),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .busy_o      (b_busy),
    .raddr_o     (b_raddr),
    .waddr_o     (b_waddr),
    .wr_en_o     (b_wr),
    .wr_coef_o   (b_coef),
    .wr_rhs_o    (b_rhs),
    .wr_ans_o    (b_ans),
    .rd_lo_i     (rd_lo),
    .rd_ce_i     (rd_ce),
    .rd_up_i     (rd_up),
    .rd_rh_i     (rd_rh),
    .rd_an_i     (rd_an),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .solution_o  (solution_o),
    .final_res_o (final_res_o),
    .status_o    (status_o)
  );

`ifndef ASSERT_OFF
  a_no_row_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !b_busy)
    else $error("row accepted while solve in progress");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job queue overflow");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_we |-> (b_wr == '0))
    else $error("intake and solver write the stores together");

  a_few_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_FEW) |-> final_res_o)
    else $error("short system result not marked final");
`endif

endmodule

### hw/rtl/tts_ram.sv
// Generic single write port RAM with registered read.
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tts_front.sv
// Row intake: counts rows, flags overflow and posts a solve job on the last row.
module tts_front #(
  parameter int MAX_ROWS = tts_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        last_row_i,
  input  logic                        hold_i,
  output logic                        wr_en_o,
  output logic [$clog2(MAX_ROWS)-1:0] waddr_o,
  output logic                        job_push_o,
  output tts_pkg::job_t               job_o
);
  import tts_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  logic [CNT_W-1:0] cnt_q, cnt_d, rows_new;
  logic [1:0]       err_q, err_d, err_new;
  logic             acc, room;

  assign in_stall_o = hold_i;
  assign acc        = in_valid_i & ~hold_i;
  assign room       = cnt_q < CNT_W'(MAX_ROWS);
  assign rows_new   = cnt_q + CNT_W'(room);
  assign err_new    = room ? err_q : STAT_CAP;

  assign wr_en_o    = acc & room;
  assign waddr_o    = cnt_q[AW-1:0];
  assign job_push_o = acc & last_row_i;
  assign job_o      = '{rows: rows_new, err: err_new, few: (rows_new < CNT_W'(4))};

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (acc) begin
      if (last_row_i) begin
        cnt_d = '0;
        err_d = STAT_OK;
      end else begin
        cnt_d = rows_new;
        err_d = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= STAT_OK;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

endmodule

### hw/rtl/tts_queue.sv
// Two-entry job queue between intake and solver.
module tts_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tts_pkg::job_t job_i,
  input  logic          pop_i,
  output tts_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);
  import tts_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

### hw/rtl/tts_div.sv
// Dual-lane radix-4 saturating fixed point divider sharing one denominator.
module tts_div #(
  parameter int FRAC_BITS = tts_pkg::DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tts_pkg::div_req_t req_i,
  output tts_pkg::div_rsp_t rsp_o
);
  import tts_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS + ((DATA_W + FRAC_BITS) % 2);
  localparam int STEPS = NUM_W / 2;
  localparam int CNT_B = $clog2(STEPS + 1);

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_PREP = 2'd1;
  localparam logic [1:0] DS_RUN  = 2'd2;
  localparam logic [1:0] DS_FIN  = 2'd3;

  logic [1:0]               state_q;
  logic [CNT_B-1:0]         cnt_q;
  logic                     done_q;
  logic signed [DATA_W-1:0] n1_q, n2_q, den_q, q1_q, q2_q;
  logic [NUM_W-1:0]         a1_q, a2_q, a1_n, a2_n;
  logic [DATA_W-1:0]        r1_q, r2_q, r1_n, r2_n, dm_q;
  logic                     zero_q;

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? -v : v;
  endfunction

  function automatic logic [NUM_W+DATA_W-1:0] step2(input logic [NUM_W-1:0] a,
                                                    input logic [DATA_W-1:0] r,
                                                    input logic [DATA_W-1:0] d);
    logic [DATA_W:0]   t;
    logic [NUM_W-1:0]  aa;
    logic [DATA_W-1:0] rr;
    aa = a;
    rr = r;
    for (int j = 0; j < 2; j++) begin
      t = {rr, aa[NUM_W-1]};
      if (t >= {1'b0, d}) begin
        t  = t - {1'b0, d};
        aa = {aa[NUM_W-2:0], 1'b1};
      end else begin
        aa = {aa[NUM_W-2:0], 1'b0};
      end
      rr = t[DATA_W-1:0];
    end
    return {aa, rr};
  endfunction

  function automatic logic signed [DATA_W-1:0] fin(input logic [NUM_W-1:0] q,
                                                   input logic signed [DATA_W-1:0] n,
                                                   input logic dz,
                                                   input logic neg);
    if (dz) begin
      if (n == '0) begin
        return '0;
      end
      return n[DATA_W-1] ? Q_MIN : Q_MAX;
    end
    if (neg) begin
      if ((|q[NUM_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]))) begin
        return Q_MIN;
      end
      return -q[DATA_W-1:0];
    end
    if (|q[NUM_W-1:DATA_W-1]) begin
      return Q_MAX;
    end
    return q[DATA_W-1:0];
  endfunction

  assign {a1_n, r1_n} = step2(a1_q, r1_q, dm_q);
  assign {a2_n, r2_n} = step2(a2_q, r2_q, dm_q);

  assign rsp_o = '{done: done_q, zero: zero_q, q1: q1_q, q2: q2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == DS_FIN);
      unique case (state_q)
        DS_IDLE: begin
          if (req_i.start) begin
            state_q <= DS_PREP;
          end
        end
        DS_PREP: begin
          cnt_q   <= CNT_B'(STEPS);
          state_q <= DS_RUN;
        end
        DS_RUN: begin
          cnt_q <= cnt_q - CNT_B'(1);
          if (cnt_q == CNT_B'(1)) begin
            state_q <= DS_FIN;
          end
        end
        DS_FIN: begin
          state_q <= DS_IDLE;
        end
        default: state_q <= DS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DS_IDLE: begin
        if (req_i.start) begin
          n1_q  <= req_i.num1;
          n2_q  <= req_i.num2;
          den_q <= req_i.den;
        end
      end
      DS_PREP: begin
        a1_q <= NUM_W'(mag(n1_q)) << FRAC_BITS;
        a2_q <= NUM_W'(mag(n2_q)) << FRAC_BITS;
        r1_q <= '0;
        r2_q <= '0;
        dm_q <= mag(den_q);
      end
      DS_RUN: begin
        a1_q <= a1_n;
        a2_q <= a2_n;
        r1_q <= r1_n;
        r2_q <= r2_n;
      end
      DS_FIN: begin
        zero_q <= (den_q == '0);
        q1_q   <= fin(a1_q, n1_q, den_q == '0, n1_q[DATA_W-1] ^ den_q[DATA_W-1]);
        q2_q   <= fin(a2_q, n2_q, den_q == '0, n2_q[DATA_W-1] ^ den_q[DATA_W-1]);
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/tts_back.sv
// Solve sequencer: two-way elimination, middle solve, outward substitution, output.
module tts_back #(
  parameter int MAX_ROWS  = tts_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = tts_pkg::DEF_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   job_valid_i,
  input  tts_pkg::job_t                          job_i,
  output logic                                   job_pop_o,
  output logic                                   busy_o,
  output logic [$clog2(MAX_ROWS)-1:0]            raddr_o,
  output logic [$clog2(MAX_ROWS)-1:0]            waddr_o,
  output tts_pkg::wr_en_t                        wr_en_o,
  output logic signed [tts_pkg::DATA_W-1:0]      wr_coef_o,
  output logic signed [tts_pkg::DATA_W-1:0]      wr_rhs_o,
  output logic signed [tts_pkg::DATA_W-1:0]      wr_ans_o,
  input  logic signed [tts_pkg::DATA_W-1:0]      rd_lo_i,
  input  logic signed [tts_pkg::DATA_W-1:0]      rd_ce_i,
  input  logic signed [tts_pkg::DATA_W-1:0]      rd_up_i,
  input  logic signed [tts_pkg::DATA_W-1:0]      rd_rh_i,
  input  logic signed [tts_pkg::DATA_W-1:0]      rd_an_i,
  output tts_pkg::div_req_t                      div_req_o,
  input  tts_pkg::div_rsp_t                      div_rsp_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [tts_pkg::DATA_W-1:0]      solution_o,
  output logic                                   final_res_o,
  output logic [1:0]                             status_o
);
  import tts_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  localparam logic [3:0] BS_IDLE = 4'd0;
  localparam logic [3:0] BS_RD   = 4'd1;
  localparam logic [3:0] BS_LAT  = 4'd2;
  localparam logic [3:0] BS_M1   = 4'd3;
  localparam logic [3:0] BS_M2   = 4'd4;
  localparam logic [3:0] BS_M3   = 4'd5;
  localparam logic [3:0] BS_M4   = 4'd6;
  localparam logic [3:0] BS_M5   = 4'd7;
  localparam logic [3:0] BS_WAIT = 4'd8;
  localparam logic [3:0] BS_ORD  = 4'd9;
  localparam logic [3:0] BS_OLD  = 4'd10;
  localparam logic [3:0] BS_FEW  = 4'd11;

  localparam logic [2:0] PH_FWD  = 3'd0;
  localparam logic [2:0] PH_BWD  = 3'd1;
  localparam logic [2:0] PH_MID  = 3'd2;
  localparam logic [2:0] PH_SUBU = 3'd3;
  localparam logic [2:0] PH_SUBD = 3'd4;

  logic [3:0]               state_q, state_d;
  logic [2:0]               ph_q, ph_d;
  logic                     pivot_q, pivot_d;
  logic                     ov_q, ov_d;
  job_t                     job_q, job_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0] lo_q, lo_d, ce_q, ce_d, up_q, up_d, rh_q, rh_d;
  logic signed [DATA_W-1:0] pu_q, pu_d, pr_q, pr_d, fu_q, fu_d, fr_q, fr_d;
  logic signed [DATA_W-1:0] t_q, t_d, num_q, num_d, pa_q, pa_d, ak_q, ak_d;
  logic signed [DATA_W-1:0] sol_q, sol_d;
  logic                     fin_q, fin_d;
  logic [1:0]               stat_q, stat_d;
  logic signed [2*DATA_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] mul_a, mul_b, x, y, qm, ans;
  logic [CNT_W-1:0]         rows_m1, half_m1;
  logic [AW-1:0]            nm1, kk;
  logic                     out_free, mid;

  function automatic logic signed [DATA_W-1:0] qmul(input logic signed [2*DATA_W-1:0] p);
    logic signed [2*DATA_W-1:0] s;
    s = p >>> FRAC_BITS;
    if (s[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){s[2*DATA_W-1]}}) begin
      return s[2*DATA_W-1] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  assign rows_m1 = job_q.rows - CNT_W'(1);
  assign half_m1 = (job_q.rows >> 1) - CNT_W'(1);
  assign nm1     = rows_m1[AW-1:0];
  assign kk      = half_m1[AW-1:0];
  assign mid     = (ph_q == PH_MID);
  assign x       = (ph_q == PH_FWD || ph_q == PH_SUBU) ? lo_q : up_q;
  assign y       = (ph_q == PH_FWD) ? up_q : lo_q;
  assign qm      = qmul(prod_q);
  assign ans     = qsub(rh_q, qm);
  assign prod_d  = mul_a * mul_b;

  assign out_free    = ~ov_q | ~out_stall_i;
  assign busy_o      = (state_q != BS_IDLE);
  assign raddr_o     = idx_q;
  assign waddr_o     = idx_q;
  assign wr_coef_o   = div_rsp_i.q1;
  assign wr_rhs_o    = div_rsp_i.q2;
  assign wr_ans_o    = (state_q == BS_WAIT) ? div_rsp_i.q1 : ans;
  assign out_valid_o = ov_q;
  assign solution_o  = sol_q;
  assign final_res_o = fin_q;
  assign status_o    = stat_q;

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    pivot_d   = pivot_q;
    ov_d      = ov_q;
    job_d     = job_q;
    idx_d     = idx_q;
    lo_d      = lo_q;
    ce_d      = ce_q;
    up_d      = up_q;
    rh_d      = rh_q;
    pu_d      = pu_q;
    pr_d      = pr_q;
    fu_d      = fu_q;
    fr_d      = fr_q;
    t_d       = t_q;
    num_d     = num_q;
    pa_d      = pa_q;
    ak_d      = ak_q;
    sol_d     = sol_q;
    fin_d     = fin_q;
    stat_d    = stat_q;
    job_pop_o = 1'b0;
    wr_en_o   = '0;
    mul_a     = x;
    mul_b     = pu_q;
    div_req_o = '{start: 1'b0, num1: y, num2: ans, den: t_q};

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      BS_M1: begin
        if (mid) begin
          mul_a = up_q;
        end else if (ph_q == PH_SUBU || ph_q == PH_SUBD) begin
          mul_b = pa_q;
        end
      end
      BS_M2: begin
        mul_a = mid ? lo_q : x;
        mul_b = mid ? fu_q : pr_q;
      end
      BS_M3: begin
        mul_a = up_q;
        mul_b = pr_q;
      end
      BS_M4: begin
        mul_a = lo_q;
        mul_b = fr_q;
      end
      default: ;
    endcase

    unique case (state_q)
      BS_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          pivot_d   = 1'b0;
          if (job_i.few) begin
            state_d = BS_FEW;
          end else begin
            ph_d    = PH_FWD;
            idx_d   = '0;
            pu_d    = '0;
            pr_d    = '0;
            state_d = BS_RD;
          end
        end
      end
      BS_RD: state_d = BS_LAT;
      BS_LAT: begin
        lo_d    = rd_lo_i;
        ce_d    = rd_ce_i;
        up_d    = rd_up_i;
        rh_d    = rd_rh_i;
        state_d = BS_M1;
      end
      BS_M1: state_d = BS_M2;
      BS_M2: begin
        if (ph_q == PH_SUBU || ph_q == PH_SUBD) begin
          wr_en_o.an = 1'b1;
          pa_d       = ans;
          state_d    = BS_RD;
          if (ph_q == PH_SUBU) begin
            if (idx_q == nm1) begin
              ph_d  = PH_SUBD;
              idx_d = kk - AW'(1);
              pa_d  = ak_q;
            end else begin
              idx_d = idx_q + AW'(1);
            end
          end else if (idx_q == '0) begin
            idx_d   = '0;
            state_d = BS_ORD;
          end else begin
            idx_d = idx_q - AW'(1);
          end
        end else begin
          t_d     = qsub(ce_q, qm);
          state_d = BS_M3;
        end
      end
      BS_M3: begin
        if (mid) begin
          t_d     = qsub(t_q, qm);
          state_d = BS_M4;
        end else begin
          div_req_o.start = 1'b1;
          state_d         = BS_WAIT;
        end
      end
      BS_M4: begin
        num_d   = ans;
        state_d = BS_M5;
      end
      BS_M5: begin
        div_req_o = '{start: 1'b1, num1: qsub(num_q, qm), num2: '0, den: t_q};
        state_d   = BS_WAIT;
      end
      BS_WAIT: begin
        if (div_rsp_i.done) begin
          pivot_d = pivot_q | div_rsp_i.zero;
          state_d = BS_RD;
          unique case (ph_q)
            PH_FWD: begin
              wr_en_o.up = 1'b1;
              wr_en_o.rh = 1'b1;
              if (idx_q == kk - AW'(1)) begin
                fu_d  = div_rsp_i.q1;
                fr_d  = div_rsp_i.q2;
                pu_d  = '0;
                pr_d  = '0;
                ph_d  = PH_BWD;
                idx_d = nm1;
              end else begin
                pu_d  = div_rsp_i.q1;
                pr_d  = div_rsp_i.q2;
                idx_d = idx_q + AW'(1);
              end
            end
            PH_BWD: begin
              wr_en_o.lo = 1'b1;
              wr_en_o.rh = 1'b1;
              pu_d       = div_rsp_i.q1;
              pr_d       = div_rsp_i.q2;
              if (idx_q == kk + AW'(1)) begin
                ph_d  = PH_MID;
                idx_d = kk;
              end else begin
                idx_d = idx_q - AW'(1);
              end
            end
            PH_MID: begin
              wr_en_o.an = 1'b1;
              ak_d       = div_rsp_i.q1;
              pa_d       = div_rsp_i.q1;
              ph_d       = PH_SUBU;
              idx_d      = kk + AW'(1);
            end
            default: state_d = BS_IDLE;
          endcase
        end
      end
      BS_ORD: state_d = BS_OLD;
      BS_OLD: begin
        if (out_free) begin
          ov_d   = 1'b1;
          sol_d  = rd_an_i;
          fin_d  = (idx_q == nm1);
          stat_d = pivot_q ? STAT_PIVOT : job_q.err;
          if (idx_q == nm1) begin
            state_d = BS_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = BS_ORD;
          end
        end
      end
      BS_FEW: begin
        if (out_free) begin
          ov_d    = 1'b1;
          sol_d   = '0;
          fin_d   = 1'b1;
          stat_d  = STAT_FEW;
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      ph_q    <= PH_FWD;
      pivot_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      pivot_q <= pivot_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    idx_q  <= idx_d;
    lo_q   <= lo_d;
    ce_q   <= ce_d;
    up_q   <= up_d;
    rh_q   <= rh_d;
    pu_q   <= pu_d;
    pr_q   <= pr_d;
    fu_q   <= fu_d;
    fr_q   <= fr_d;
    t_q    <= t_d;
    num_q  <= num_d;
    pa_q   <= pa_d;
    ak_q   <= ak_d;
    sol_q  <= sol_d;
    fin_q  <= fin_d;
    stat_q <= stat_d;
    prod_q <= prod_d;
  end

endmodule
